### rtl/core/ppa_pkg.sv
// Shared types and constants for the polygon perimeter accumulator.
package ppa_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned SqW         = 2 * DiffW;
  localparam int unsigned RootW       = SqW / 2;
  localparam int unsigned RemW        = RootW + 2;
  localparam int unsigned RootCntW    = $clog2(RootW + 1);
  localparam int unsigned SumW        = 48;
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned CountW      = $clog2(MaxVertices + 1);

  localparam logic [SumW-1:0] SumMax = '1;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [SumW-1:0] perimeter;
    logic            saturated;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

endpackage

### rtl/core/polygon_perimeter_accumulator_core.sv
// Streaming closed-polygon perimeter: sequencer, shared squarer and saturating sum.
//
// Vertices enter on the in channel (valid/ready) as signed Q16.16 x and y,
// with last_vertex set on the final vertex of a polygon. The perimeter
// leaves on the out channel (valid/ready) as unsigned Q32.16 with a flag
// that tells whether the sum clamped at its maximum.
// The first vertex of a polygon is only stored. Every later vertex
// costs one edge: a difference step, squaring dx and then dy on the shared
// 33x33 squarer, the square root (a start, 33 bit-serial steps and a
// done) and the saturating add; no further vertex is taken until that
// edge is done. The last vertex also runs the closing edge
// plus a result load before the perimeter appears.
// in_ready_o is high only while the sequencer is idle.
// Reset clears the polygon state and empties the output register. If the
// receiver stalls, the finished result waits in the output register while
// further vertices of the next polygon are still taken; only the next
// result load waits until the pending one has been transferred.
// A polygon of one vertex gives a perimeter of zero.
module polygon_perimeter_accumulator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ppa_pkg::vertex_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ppa_pkg::result_t out_data_o
);
  import ppa_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDiff = 7'b0000010,
    StSqX  = 7'b0000100,
    StSqY  = 7'b0001000,
    StRoot = 7'b0010000,
    StAdd  = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CoordW-1:0] cur_x_q, cur_y_q;
  logic                     last_q;
  logic                     closing_q;
  logic [CountW-1:0]        count_q;
  logic [SumW-1:0]          sum_q;
  logic                     ovf_q;
  logic [DiffW-1:0]         dx_q, dy_q;
  logic [SqW-1:0]           sq_q;
  logic                     start_q;
  logic                     out_valid_q;
  result_t                  out_q;

  logic                     in_xfer;
  logic                     out_free;
  logic signed [CoordW-1:0] ref_x, ref_y;
  logic [DiffW-1:0]         diff_x, diff_y, mag_x, mag_y;
  logic [DiffW-1:0]         mul_op;
  logic [SqW-1:0]           product;
  logic [SumW:0]            sum_ext;
  sqrt_status_t             sqrt_status;
  logic [RootW-1:0]         root;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // The closing edge runs from the last vertex back to the first one.
  assign ref_x  = closing_q ? first_x_q : prev_x_q;
  assign ref_y  = closing_q ? first_y_q : prev_y_q;
  assign diff_x = {cur_x_q[CoordW-1], cur_x_q} - {ref_x[CoordW-1], ref_x};
  assign diff_y = {cur_y_q[CoordW-1], cur_y_q} - {ref_y[CoordW-1], ref_y};
  assign mag_x  = diff_x[DiffW-1] ? (~diff_x + DiffW'(1)) : diff_x;
  assign mag_y  = diff_y[DiffW-1] ? (~diff_y + DiffW'(1)) : diff_y;

  assign mul_op  = (state_q == StSqX) ? dx_q : dy_q;
  assign product = SqW'(mul_op) * SqW'(mul_op);

  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(root);

  ppa_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .radicand_i (sq_q),
    .status_o   (sqrt_status),
    .root_o     (root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (count_q != '0) begin
            state_d = StDiff;
          end else if (in_data_i.last_vertex) begin
            state_d = StFin;
          end
        end
      end
      StDiff: state_d = StSqX;
      StSqX:  state_d = StSqY;
      StSqY:  state_d = StRoot;
      StRoot: begin
        if (sqrt_status.done) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        if (last_q && !closing_q) begin
          state_d = StDiff;
        end else if (last_q) begin
          state_d = StFin;
        end else begin
          state_d = StIdle;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == StSqY);

      if (out_valid_q && out_ready_i && state_q != StFin) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        last_q    <= in_data_i.last_vertex;
        closing_q <= 1'b0;
        if (count_q == '0) begin
          first_x_q <= in_data_i.vertex_x;
          first_y_q <= in_data_i.vertex_y;
          prev_x_q  <= in_data_i.vertex_x;
          prev_y_q  <= in_data_i.vertex_y;
        end
        if (count_q < CountW'(MaxVertices)) begin
          count_q <= count_q + CountW'(1);
        end
      end

      if (state_q == StDiff && !closing_q) begin
        prev_x_q <= cur_x_q;
        prev_y_q <= cur_y_q;
      end

      if (state_q == StAdd) begin
        closing_q <= 1'b1;
        if (sum_ext[SumW]) begin
          sum_q <= SumMax;
          ovf_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SumW-1:0];
        end
      end

      // Hand the perimeter over and start a fresh polygon.
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
        first_x_q   <= '0;
        first_y_q   <= '0;
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        count_q     <= '0;
        sum_q       <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_x_q <= in_data_i.vertex_x;
      cur_y_q <= in_data_i.vertex_y;
    end
    if (state_q == StDiff) begin
      dx_q <= mag_x;
      dy_q <= mag_y;
    end
    if (state_q == StSqX) begin
      sq_q <= product;
    end else if (state_q == StSqY) begin
      sq_q <= sq_q + product;
    end
    if (state_q == StFin && out_free) begin
      out_q.perimeter <= sum_q;
      out_q.saturated <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/ppa_isqrt.sv
// Iterative floored integer square root, one result bit per cycle.
module ppa_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppa_pkg::SqW-1:0]     radicand_i,
  output ppa_pkg::sqrt_status_t       status_o,
  output logic [ppa_pkg::RootW-1:0]   root_o
);
  import ppa_pkg::*;

  logic [SqW-1:0]      rad_q, rad_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [RootCntW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [RemW+1:0]     rem_sh;
  logic [RemW+1:0]     trial;

  // Bring down the next two radicand bits and try appending a one to the root.
  assign rem_sh = {rem_q, rad_q[SqW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = RootCntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = RemW'(rem_sh - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rem_sh);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - RootCntW'(1);
      if (cnt_q == RootCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign root_o        = root_q;

endmodule

### rtl/core/ppa_checker.sv
// Port-level checks for the perimeter accumulator, bound to the top level.
module ppa_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input ppa_pkg::vertex_t in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ppa_pkg::result_t out_data_o
);
  import ppa_pkg::*;

  // A stalled result stays put until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // A clamped sum always reads as the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.perimeter == SumMax)
    else $error("saturated result below the maximum");

  // A new result is loaded only while the sequencer is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the block was idle");

  // Input is refused for the cycle after a transfer that closes a polygon.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_vertex |=> !in_ready_o)
    else $error("ready stayed high after a closing vertex");

endmodule

bind polygon_perimeter_accumulator_core ppa_checker u_ppa_checker (.*);
